// ----- hw/rtl/clipped_framebuffer_fill_blit_macros.svh -----
// Assertion macros shared by the clipped framebuffer fill and blit RTL.
`ifndef CLIPPED_FRAMEBUFFER_FILL_BLIT_MACROS_SVH
`define CLIPPED_FRAMEBUFFER_FILL_BLIT_MACROS_SVH

`ifndef ASSERT_OFF
// Checked on every rising clock edge outside reset.
`define CFB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked on every rising clock edge, reset included.
`define CFB_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CFB_ASSERT(lbl, prop, msg)
`define CFB_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ----- hw/rtl/cfb_pkg.sv -----
// Types, codes and helpers shared by the framebuffer fill and blit engine.
`default_nettype none
package cfb_pkg;

  // Default store geometry.
  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 256;

  // Signed width for clip and bound arithmetic: 16-bit origins plus sizes.
  localparam int SW = 18;
  typedef logic signed [SW-1:0] coord_t;

  // Item kinds.
  localparam logic [2:0] KIND_PLOT      = 3'd0;
  localparam logic [2:0] KIND_FILL_RECT = 3'd1;
  localparam logic [2:0] KIND_FILL_ALL  = 3'd2;
  localparam logic [2:0] KIND_IMG_START = 3'd3;
  localparam logic [2:0] KIND_IMG_PIXEL = 3'd4;
  localparam logic [2:0] KIND_READ      = 3'd5;

  // Configuration register indexes.
  localparam int CFG_IW = 3;
  localparam int CFG_DW = 9;
  localparam logic [CFG_IW-1:0] CFG_FRAME_WIDTH  = 3'd0;
  localparam logic [CFG_IW-1:0] CFG_FRAME_HEIGHT = 3'd1;
  localparam logic [CFG_IW-1:0] CFG_CLIP_LEFT    = 3'd2;
  localparam logic [CFG_IW-1:0] CFG_CLIP_TOP     = 3'd3;
  localparam logic [CFG_IW-1:0] CFG_CLIP_WIDTH   = 3'd4;
  localparam logic [CFG_IW-1:0] CFG_CLIP_HEIGHT  = 3'd5;

  typedef struct packed {
    logic [2:0]         kind;
    logic signed [15:0] x_pos;
    logic signed [15:0] y_pos;
    logic signed [15:0] rect_width;
    logic signed [15:0] rect_height;
    logic [15:0]        color;
  } in_item_t;

  typedef struct packed {
    logic [15:0] read_data;
    logic        read_inside;
  } out_item_t;

  // Frame store access command.
  typedef struct packed {
    logic wr;
    logic rd;
  } mem_cmd_t;

  // Exchange the two bytes of a pixel word.
  function automatic logic [15:0] swap_bytes(input logic [15:0] c);
    return {c[7:0], c[15:8]};
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/clipped_framebuffer_fill_blit.sv -----
// Clipped RGB565 fill and blit engine: top level with command sequencer.
// Plot and image pixel items write the store in the cycle after the accept, one item per cycle
// while in_stall is low. Read items pass the command stage, store read register and output
// register, one per cycle when out is free. Rectangle and frame fills hold in_stall through a
// setup state and, unless the fill is empty, a sweep on the frame store's single write port.
// Reset (rst_n low, synchronous) restores the registers and closes any image; the store is kept.
`default_nettype none
module clipped_framebuffer_fill_blit #(
  parameter int MAX_WIDTH  = cfb_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = cfb_pkg::DEF_MAX_HEIGHT
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // Input item channel
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire cfb_pkg::in_item_t           in_data,
  // Result channel
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output cfb_pkg::out_item_t               out_data,
  // Configuration write channel
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [cfb_pkg::CFG_IW-1:0]  cfg_index,
  input  wire logic [cfb_pkg::CFG_DW-1:0]  cfg_data
);

`include "clipped_framebuffer_fill_blit_macros.svh"

  localparam int XW  = $clog2(MAX_WIDTH);
  localparam int YW  = $clog2(MAX_HEIGHT);
  localparam int EWW = $clog2(MAX_WIDTH + 1);
  localparam int EHW = $clog2(MAX_HEIGHT + 1);
  localparam int SW  = cfb_pkg::SW;

  // Sequencer states.
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_PLOT  = 3'd1;
  localparam logic [2:0] ST_READ  = 3'd2;
  localparam logic [2:0] ST_RECT  = 3'd3;
  localparam logic [2:0] ST_FRAME = 3'd4;
  localparam logic [2:0] ST_SWEEP = 3'd5;

  // Configuration registers.
  logic [8:0] fw_r, fh_r, cw_r, ch_r;
  logic [7:0] cl_r, ct_r;

  // Image stream state.
  logic signed [15:0] img_ox_r, img_oy_r, img_w_r, img_h_r;
  logic [15:0]        img_col_r, img_row_r;
  logic               img_active_r;
  logic [15:0]        img_col_inc, img_row_inc;

  // Command stage.
  logic [2:0]          b_state_r, b_state_nxt;
  cfb_pkg::coord_t     b_x_r, b_y_r, b_w_r, b_h_r;
  logic [15:0]         b_color_r;
  logic                b_done;

  // Fill sweep.
  logic [XW-1:0]       sx1_r, cur_x_r;
  logic [YW-1:0]       cur_y_r;
  logic [EWW-1:0]      sx2_r;
  logic [EHW-1:0]      sy2_r;
  logic                row_end, sweep_last;

  // Read return path.
  logic                c_valid_r, c_valid_nxt, c_inside_r;
  logic                c_moves, c_free;
  logic                out_valid_r;
  cfb_pkg::out_item_t  out_data_r;

  logic                in_acc;
  logic [EWW-1:0]      eff_w;
  logic [EHW-1:0]      eff_h;
  cfb_pkg::coord_t     eff_w_s, eff_h_s, cl_s, ct_s, cr_s, cb_s;
  cfb_pkg::coord_t     img_px, img_py;
  cfb_pkg::coord_t     xe, ye, x1, y1, xc, yc, x2, y2;
  logic                fill_empty, b_in_frame, b_in_clip;

  cfb_pkg::mem_cmd_t   mem_cmd;
  logic [XW-1:0]       mem_x;
  logic [YW-1:0]       mem_y;
  logic [15:0]         mem_rdata;

  // Effective frame size saturates at the store geometry.
  assign eff_w = (32'(fw_r) > MAX_WIDTH)  ? EWW'(MAX_WIDTH)  : EWW'(fw_r);
  assign eff_h = (32'(fh_r) > MAX_HEIGHT) ? EHW'(MAX_HEIGHT) : EHW'(fh_r);

  assign eff_w_s = $signed(SW'(eff_w));
  assign eff_h_s = $signed(SW'(eff_h));
  assign cl_s    = $signed(SW'(cl_r));
  assign ct_s    = $signed(SW'(ct_r));
  assign cr_s    = $signed(SW'(cl_r) + SW'(cw_r));
  assign cb_s    = $signed(SW'(ct_r) + SW'(ch_r));

  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && !in_stall;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r <= 9'd256;
      fh_r <= 9'd256;
      cl_r <= 8'd0;
      ct_r <= 8'd0;
      cw_r <= 9'd256;
      ch_r <= 9'd256;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        cfb_pkg::CFG_FRAME_WIDTH:  fw_r <= cfg_data;
        cfb_pkg::CFG_FRAME_HEIGHT: fh_r <= cfg_data;
        cfb_pkg::CFG_CLIP_LEFT:    cl_r <= cfg_data[7:0];
        cfb_pkg::CFG_CLIP_TOP:     ct_r <= cfg_data[7:0];
        cfb_pkg::CFG_CLIP_WIDTH:   cw_r <= cfg_data;
        cfb_pkg::CFG_CLIP_HEIGHT:  ch_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Image pixel position and stream counters.
  assign img_px      = $signed(SW'(img_ox_r) + SW'(img_col_r));
  assign img_py      = $signed(SW'(img_oy_r) + SW'(img_row_r));
  assign img_col_inc = img_col_r + 16'd1;
  assign img_row_inc = img_row_r + 16'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_ox_r     <= '0;
      img_oy_r     <= '0;
      img_w_r      <= '0;
      img_h_r      <= '0;
      img_col_r    <= '0;
      img_row_r    <= '0;
      img_active_r <= 1'b0;
    end else if (in_acc) begin
      if (in_data.kind == cfb_pkg::KIND_IMG_START) begin
        img_ox_r     <= in_data.x_pos;
        img_oy_r     <= in_data.y_pos;
        img_w_r      <= in_data.rect_width;
        img_h_r      <= in_data.rect_height;
        img_col_r    <= '0;
        img_row_r    <= '0;
        img_active_r <= (in_data.rect_width > 16'sd0) && (in_data.rect_height > 16'sd0);
      end else if (in_data.kind == cfb_pkg::KIND_IMG_PIXEL && img_active_r) begin
        // The column stays below the width, so reaching it ends the row.
        if (img_col_inc == $unsigned(img_w_r)) begin
          img_col_r <= '0;
          if (img_row_inc == $unsigned(img_h_r)) begin
            img_row_r    <= '0;
            img_active_r <= 1'b0;
          end else begin
            img_row_r <= img_row_inc;
          end
        end else begin
          img_col_r <= img_col_inc;
        end
      end
    end
  end

  // Read return handshake: the memory read register feeds the output register.
  assign c_moves = c_valid_r && (!out_valid_r || !out_stall);
  assign c_free  = !c_valid_r || c_moves;

  // Window checks for the single-pixel commands.
  assign b_in_frame = (b_x_r >= 0) && (b_y_r >= 0) && (b_x_r < eff_w_s) && (b_y_r < eff_h_s);
  assign b_in_clip  = (b_x_r >= cl_s) && (b_x_r < cr_s) && (b_y_r >= ct_s) && (b_y_r < cb_s);

  // Fill bounds: rectangle against the clip and the frame, or the whole frame.
  always_comb begin
    xe = b_x_r + b_w_r;
    ye = b_y_r + b_h_r;
    xc = (xe < cr_s) ? xe : cr_s;
    yc = (ye < cb_s) ? ye : cb_s;
    if (b_state_r == ST_FRAME) begin
      x1 = '0;
      y1 = '0;
      x2 = eff_w_s;
      y2 = eff_h_s;
    end else begin
      x1 = (b_x_r > cl_s) ? b_x_r : cl_s;
      y1 = (b_y_r > ct_s) ? b_y_r : ct_s;
      x2 = (xc < eff_w_s) ? xc : eff_w_s;
      y2 = (yc < eff_h_s) ? yc : eff_h_s;
    end
    fill_empty = (x1 >= x2) || (y1 >= y2);
  end

  // Sweep position tests.
  assign row_end    = (EWW'(cur_x_r) + EWW'(1)) == sx2_r;
  assign sweep_last = row_end && ((EHW'(cur_y_r) + EHW'(1)) == sy2_r);

  // Whether the command stage can take a new item at the next edge.
  always_comb begin
    unique case (b_state_r)
      ST_IDLE, ST_PLOT:   b_done = 1'b1;
      ST_READ:            b_done = c_free;
      ST_RECT, ST_FRAME:  b_done = 1'b0;
      ST_SWEEP:           b_done = sweep_last;
      default:            b_done = 1'b1;
    endcase
  end

  assign in_stall = !b_done;

  // Sequencer next state.
  always_comb begin
    b_state_nxt = b_state_r;
    if (b_done) begin
      b_state_nxt = ST_IDLE;
      if (in_acc) begin
        unique case (in_data.kind)
          cfb_pkg::KIND_PLOT:      b_state_nxt = ST_PLOT;
          cfb_pkg::KIND_FILL_RECT: b_state_nxt = ST_RECT;
          cfb_pkg::KIND_FILL_ALL:  b_state_nxt = ST_FRAME;
          cfb_pkg::KIND_IMG_PIXEL: b_state_nxt = img_active_r ? ST_PLOT : ST_IDLE;
          cfb_pkg::KIND_READ:      b_state_nxt = ST_READ;
          default:                 b_state_nxt = ST_IDLE;
        endcase
      end
    end else if (b_state_r == ST_RECT || b_state_r == ST_FRAME) begin
      b_state_nxt = fill_empty ? ST_IDLE : ST_SWEEP;
    end
  end

  // Read stage valid: set when a read leaves the command stage, cleared on hand-off.
  always_comb begin
    c_valid_nxt = c_valid_r;
    if (b_state_r == ST_READ && c_free) begin
      c_valid_nxt = 1'b1;
    end else if (c_moves) begin
      c_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_state_r   <= ST_IDLE;
      c_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      b_state_r <= b_state_nxt;
      c_valid_r <= c_valid_nxt;
      if (c_moves) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Command payload, sweep position and result payload.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      if (in_data.kind == cfb_pkg::KIND_IMG_PIXEL) begin
        b_x_r <= img_px;
        b_y_r <= img_py;
      end else begin
        b_x_r <= SW'(in_data.x_pos);
        b_y_r <= SW'(in_data.y_pos);
      end
      b_w_r     <= SW'(in_data.rect_width);
      b_h_r     <= SW'(in_data.rect_height);
      b_color_r <= cfb_pkg::swap_bytes(in_data.color);
    end
    if (b_state_r == ST_RECT || b_state_r == ST_FRAME) begin
      sx1_r   <= XW'(x1);
      sx2_r   <= EWW'(x2);
      sy2_r   <= EHW'(y2);
      cur_x_r <= XW'(x1);
      cur_y_r <= YW'(y1);
    end else if (b_state_r == ST_SWEEP) begin
      if (row_end) begin
        cur_x_r <= sx1_r;
        cur_y_r <= cur_y_r + YW'(1);
      end else begin
        cur_x_r <= cur_x_r + XW'(1);
      end
    end
    if (b_state_r == ST_READ && c_free) begin
      c_inside_r <= b_in_frame;
    end
    if (c_moves) begin
      out_data_r.read_data   <= c_inside_r ? mem_rdata : 16'd0;
      out_data_r.read_inside <= c_inside_r;
    end
  end

  // Frame store access.
  always_comb begin
    mem_cmd.wr = 1'b0;
    mem_cmd.rd = 1'b0;
    mem_x      = XW'(b_x_r);
    mem_y      = YW'(b_y_r);
    unique case (b_state_r)
      ST_PLOT:  mem_cmd.wr = b_in_clip && b_in_frame;
      ST_READ:  mem_cmd.rd = c_free && b_in_frame;
      ST_SWEEP: begin
        mem_cmd.wr = 1'b1;
        mem_x      = cur_x_r;
        mem_y      = cur_y_r;
      end
      default: ;
    endcase
  end

  cfb_store #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_store (
    .clk   (clk),
    .cmd   (mem_cmd),
    .x     (mem_x),
    .y     (mem_y),
    .eff_w (eff_w),
    .wdata (b_color_r),
    .rdata (mem_rdata)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A read never overwrites a result that still waits for the output register.
  `CFB_ASSERT(a_rd_no_overrun, mem_cmd.rd |-> (!c_valid_r || c_moves), "read overran pending result")
  // The store takes one access per cycle.
  `CFB_ASSERT_ALWAYS(a_one_access, !(mem_cmd.wr && mem_cmd.rd), "write and read in one cycle")
  // Every write lands inside the effective frame.
  `CFB_ASSERT(a_wr_in_frame, mem_cmd.wr |-> ((EWW'(mem_x) < eff_w) && (EHW'(mem_y) < eff_h)), "write outside frame")
  // The sweep stays inside its bounds.
  `CFB_ASSERT(a_sweep_bounds, (b_state_r == ST_SWEEP) |-> ((EWW'(cur_x_r) < sx2_r) && (EHW'(cur_y_r) < sy2_r)), "sweep past bounds")
  // A new result only comes from the read stage.
  `CFB_ASSERT(a_out_source, $rose(out_valid_r) |-> $past(c_valid_r), "result without read")

endmodule
`default_nettype wire

// ----- hw/rtl/cfb_store.sv -----
// Frame store: pixel address generation and a single-port synchronous memory.
`default_nettype none
module cfb_store #(
  parameter int MAX_WIDTH  = cfb_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = cfb_pkg::DEF_MAX_HEIGHT
) (
  input  wire logic                              clk,
  input  wire cfb_pkg::mem_cmd_t                 cmd,
  input  wire logic [$clog2(MAX_WIDTH)-1:0]      x,
  input  wire logic [$clog2(MAX_HEIGHT)-1:0]     y,
  input  wire logic [$clog2(MAX_WIDTH+1)-1:0]    eff_w,
  input  wire logic [15:0]                       wdata,
  output logic [15:0]                            rdata
);

  localparam int XW    = $clog2(MAX_WIDTH);
  localparam int YW    = $clog2(MAX_HEIGHT);
  localparam int EWW   = $clog2(MAX_WIDTH + 1);
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int PW    = YW + EWW;

  logic [PW-1:0]  prod;
  logic [AW-1:0]  addr;
  logic [15:0]    mem [DEPTH];
  logic [15:0]    rdata_r;

  // Row-major address: the row stride is the effective frame width.
  assign prod = PW'(y) * PW'(eff_w);
  assign addr = AW'(prod + PW'(x));

  // One access per cycle; the read word is registered and held between reads.
  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      mem[addr] <= wdata;
    end
    if (cmd.rd) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// ----- tb/tb_clipped_framebuffer_fill_blit.sv -----
// Self-checking testbench for the clipped RGB565 fill and blit engine.
`timescale 1ns / 1ps

module tb_clipped_framebuffer_fill_blit;
  import cfb_pkg::*;

  // Kinds the engine has no use for; they must leave everything untouched.
  localparam logic [2:0] KIND_SPARE_LO = 3'd6;
  localparam logic [2:0] KIND_SPARE_HI = 3'd7;

  // Cycles without any accepted beat before the run is declared hung.
  localparam int QUIET_LIMIT = 200000;
  // Frames up to this many pixels may take unbounded rectangles and frame fills.
  localparam int ROOMY_AREA = 4096;

  // Mirror of the frame store and the image cursor, plus the readbacks still owed.
  class frame_painter;
    logic [15:0] pixels [0:65535];
    int frame_w_raw, frame_h_raw, clip_l, clip_t, clip_w, clip_h;
    int img_x, img_y, img_w, img_h, img_col, img_row;
    bit img_open;
    out_item_t readbacks_due[$];
    int errors, beats, reads_checked, pixel_writes;

    function new();
      frame_w_raw = 256;
      frame_h_raw = 256;
      clip_l = 0;
      clip_t = 0;
      clip_w = 256;
      clip_h = 256;
      img_open = 1'b0;
    endfunction

    function void write_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] val);
      case (idx)
        CFG_FRAME_WIDTH:  frame_w_raw = val;
        CFG_FRAME_HEIGHT: frame_h_raw = val;
        CFG_CLIP_LEFT:    clip_l = val[7:0];
        CFG_CLIP_TOP:     clip_t = val[7:0];
        CFG_CLIP_WIDTH:   clip_w = val;
        CFG_CLIP_HEIGHT:  clip_h = val;
        default: ;
      endcase
    endfunction

    // Frame sizes above the store geometry saturate.
    function int eff_w();
      return frame_w_raw > DEF_MAX_WIDTH ? DEF_MAX_WIDTH : frame_w_raw;
    endfunction

    function int eff_h();
      return frame_h_raw > DEF_MAX_HEIGHT ? DEF_MAX_HEIGHT : frame_h_raw;
    endfunction

    function bit in_frame(int x, int y);
      return x >= 0 && y >= 0 && x < eff_w() && y < eff_h();
    endfunction

    function bit in_clip(int x, int y);
      return x >= clip_l && x < clip_l + clip_w && y >= clip_t && y < clip_t + clip_h;
    endfunction

    // Writes outside the frame are dropped, never wrapped.
    function void put_pixel(int x, int y, logic [15:0] word);
      if (in_frame(x, y)) begin
        pixels[y * eff_w() + x] = word;
        pixel_writes++;
      end
    endfunction

    function int outstanding();
      return readbacks_due.size();
    endfunction

    function void apply_command(in_item_t it);
      int x, y, w, h, x1, y1, x2, y2, i, j, px, py;
      logic [15:0] word;
      out_item_t rd;
      x = $signed(it.x_pos);
      y = $signed(it.y_pos);
      w = $signed(it.rect_width);
      h = $signed(it.rect_height);
      word = {it.color[7:0], it.color[15:8]};
      beats++;
      case (it.kind)
        KIND_PLOT: begin
          if (in_clip(x, y)) put_pixel(x, y, word);
        end
        KIND_FILL_RECT: begin
          // Bounds at full precision, then limited by clip and frame.
          x1 = x > clip_l ? x : clip_l;
          y1 = y > clip_t ? y : clip_t;
          x2 = (x + w) < (clip_l + clip_w) ? (x + w) : (clip_l + clip_w);
          y2 = (y + h) < (clip_t + clip_h) ? (y + h) : (clip_t + clip_h);
          if (x1 < 0) x1 = 0;
          if (y1 < 0) y1 = 0;
          if (x2 > eff_w()) x2 = eff_w();
          if (y2 > eff_h()) y2 = eff_h();
          for (j = y1; j < y2; j++)
            for (i = x1; i < x2; i++)
              put_pixel(i, j, word);
        end
        KIND_FILL_ALL: begin
          for (j = 0; j < eff_h(); j++)
            for (i = 0; i < eff_w(); i++)
              put_pixel(i, j, word);
        end
        KIND_IMG_START: begin
          img_x = x;
          img_y = y;
          img_w = w;
          img_h = h;
          img_col = 0;
          img_row = 0;
          img_open = (w > 0 && h > 0);
        end
        KIND_IMG_PIXEL: begin
          // Pixels with no image open are ignored; clipped ones still advance.
          if (img_open) begin
            px = img_x + img_col;
            py = img_y + img_row;
            if (in_clip(px, py)) put_pixel(px, py, word);
            img_col++;
            if (img_col >= img_w) begin
              img_col = 0;
              img_row++;
              if (img_row >= img_h) begin
                img_row = 0;
                img_open = 1'b0;
              end
            end
          end
        end
        KIND_READ: begin
          if (in_frame(x, y)) begin
            rd.read_data = pixels[y * eff_w() + x];
            rd.read_inside = 1'b1;
          end else begin
            rd = '0;
          end
          readbacks_due.push_back(rd);
        end
        default: ;
      endcase
    endfunction

    function void check_readback(out_item_t got);
      out_item_t want;
      if (readbacks_due.size() == 0) begin
        $display("%0t: result beat with no read outstanding: expected none, actual %h/%b",
                 $time, got.read_data, got.read_inside);
        errors++;
        return;
      end
      want = readbacks_due.pop_front();
      reads_checked++;
      if (got.read_data !== want.read_data) begin
        $display("%0t: read_data mismatch: expected %h, actual %h",
                 $time, want.read_data, got.read_data);
        errors++;
      end
      if (got.read_inside !== want.read_inside) begin
        $display("%0t: read_inside mismatch: expected %b, actual %b",
                 $time, want.read_inside, got.read_inside);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_item_t in_data;
  logic out_valid;
  logic out_stall;
  out_item_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IW-1:0] cfg_index;
  logic [CFG_DW-1:0] cfg_data;

  frame_painter painter = new();
  int gap_pct;
  bit calm_out;
  int stall_run;
  int settings_used;

  clipped_framebuffer_fill_blit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Beats are taken at the edge, from the values held before it.
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) painter.apply_command(in_data);
    if (rst_n && out_valid && !out_stall) painter.check_readback(out_data);
    if (rst_n && cfg_valid && cfg_ready) painter.write_reg(cfg_index, cfg_data);
  end

  // Result-side backpressure: random stall bursts between free runs, none while calm_out is set.
  always @(posedge clk) begin
    if (calm_out) begin
      out_stall <= 1'b0;
      stall_run <= 0;
    end else if (stall_run > 0) begin
      stall_run <= stall_run - 1;
    end else if ($urandom_range(0, 2) == 0) begin
      out_stall <= 1'b1;
      stall_run <= $urandom_range(0, 15);
    end else begin
      out_stall <= 1'b0;
      stall_run <= $urandom_range(0, 39);
    end
  end

  // Hang detector: ends the run when nothing moves for too long.
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("%0t: no beat accepted for %0d cycles", $time, QUIET_LIMIT);
    $display("simulation failed");
    $finish;
  end

  function automatic int any16();
    logic signed [15:0] s;
    s = 16'($urandom);
    return s;
  endfunction

  // Mostly near the frame, sometimes at the far ends of the 16-bit range.
  function automatic int near_coord(input int span);
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return -32768;
    if (r == 1) return 32767;
    if (r == 2) return any16();
    return int'($urandom_range(0, span + 7)) - 4;
  endfunction

  function automatic int rect_extent(input bit wide, input int span);
    int r;
    r = $urandom_range(0, 9);
    if (wide && r == 0) return any16();
    if (wide && r == 1) return $urandom_range(0, 1) ? 32767 : -32768;
    if (r == 2) return -int'($urandom_range(0, 3));
    return $urandom_range(1, span);
  endfunction

  function automatic bit roomy();
    return painter.eff_w() * painter.eff_h() <= ROOMY_AREA;
  endfunction

  function automatic in_item_t make_item(input logic [2:0] kind, input int x, input int y,
                                         input int w, input int h, input logic [15:0] c);
    in_item_t it;
    it.kind = kind;
    it.x_pos = x[15:0];
    it.y_pos = y[15:0];
    it.rect_width = w[15:0];
    it.rect_height = h[15:0];
    it.color = c;
    return it;
  endfunction

  // Offer one beat, hold it until taken, then maybe go idle for a burst.
  task automatic push_item(input in_item_t it);
    in_data <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  // Stop sending and wait for every outstanding readback.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (painter.outstanding() != 0) @(posedge clk);
  endtask

  // Let writes and any running fill finish before touching the registers.
  task automatic settle_block();
    drain_results();
    repeat (6) @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic apply_setting(input logic [8:0] fw, input logic [8:0] fh,
                               input logic [8:0] cl, input logic [8:0] ct,
                               input logic [8:0] cw, input logic [8:0] ch);
    settle_block();
    write_reg(CFG_FRAME_WIDTH, fw);
    write_reg(CFG_FRAME_HEIGHT, fh);
    write_reg(CFG_CLIP_LEFT, cl);
    write_reg(CFG_CLIP_TOP, ct);
    write_reg(CFG_CLIP_WIDTH, cw);
    write_reg(CFG_CLIP_HEIGHT, ch);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  // Small frames most of the time, with empty and oversized ones mixed in.
  task automatic random_setting();
    int fw, fh, cw, ch, r;
    logic [8:0] cl, ct;
    r = $urandom_range(0, 9);
    if (r == 0) begin
      fw = 0;
      fh = $urandom_range(0, 40);
    end else if (r == 1) begin
      fw = $urandom_range(257, 511);
      fh = $urandom_range(1, 8);
    end else begin
      fw = $urandom_range(1, 48);
      fh = $urandom_range(1, 48);
    end
    cl = {1'($urandom_range(0, 3) == 0), 8'($urandom_range(0, fw > 255 ? 255 : fw))};
    ct = {1'($urandom_range(0, 3) == 0), 8'($urandom_range(0, fh > 255 ? 255 : fh))};
    cw = $urandom_range(0, 6) == 0 ? $urandom_range(0, 511) : $urandom_range(0, fw + 2);
    ch = $urandom_range(0, 6) == 0 ? $urandom_range(0, 511) : $urandom_range(0, fh + 2);
    apply_setting(fw, fh, cl, ct, cw, ch);
  endtask

  task automatic read_somewhere();
    int x, y;
    if (painter.eff_w() > 0 && painter.eff_h() > 0 && $urandom_range(0, 6) != 0) begin
      x = $urandom_range(0, painter.eff_w() - 1);
      y = $urandom_range(0, painter.eff_h() - 1);
    end else begin
      x = near_coord(painter.eff_w());
      y = near_coord(painter.eff_h());
    end
    push_item(make_item(KIND_READ, x, y, any16(), any16(), 16'($urandom)));
  endtask

  // One image: start, its pixel stream with reads woven in, then maybe a readback.
  task automatic image_burst(output int sent);
    int ox, oy, w, h, npx, k, r, reach;
    sent = 0;
    ox = near_coord(painter.eff_w());
    oy = near_coord(painter.eff_h());
    r = $urandom_range(0, 9);
    if (r == 0) begin
      w = $urandom_range(0, 1) ? 32767 : any16();
      h = $urandom_range(1, 3);
      npx = $urandom_range(1, 12);
    end else if (r == 1) begin
      w = $urandom_range(0, 1) ? -int'($urandom_range(0, 2)) : $urandom_range(1, 4);
      h = w > 0 ? -int'($urandom_range(0, 2)) : $urandom_range(1, 4);
      npx = $urandom_range(0, 2);
    end else begin
      w = $urandom_range(1, 8);
      h = $urandom_range(1, 5);
      npx = w * h;
      // Now and then the stream is cut short and left open.
      if ($urandom_range(0, 7) == 0) npx = $urandom_range(0, npx - 1);
    end
    reach = (w > 0 && w < 8) ? w : 8;
    push_item(make_item(KIND_IMG_START, ox, oy, w, h, 16'($urandom)));
    sent++;
    for (k = 0; k < npx; k++) begin
      if ($urandom_range(0, 7) == 0) begin
        push_item(make_item(KIND_READ, ox + $urandom_range(0, reach - 1),
                            oy + $urandom_range(0, 4), any16(), any16(), 16'($urandom)));
        sent++;
      end
      push_item(make_item(KIND_IMG_PIXEL, any16(), any16(), any16(), any16(), 16'($urandom)));
      sent++;
    end
    if ($urandom_range(0, 1)) begin
      push_item(make_item(KIND_READ, ox + $urandom_range(0, reach - 1),
                          oy + $urandom_range(0, 4), any16(), any16(), 16'($urandom)));
      sent++;
    end
  endtask

  task automatic random_items(input int target, input bit hold_midway);
    int made, sel, got;
    in_item_t it;
    made = 0;
    while (made < target) begin
      // When asked, the sender holds off once, halfway, until every readback is home.
      if (hold_midway && made >= target / 2) begin
        hold_midway = 1'b0;
        drain_results();
      end
      sel = $urandom_range(0, 99);
      if (sel < 28) begin
        image_burst(got);
        made += got;
      end else if (sel < 55) begin
        read_somewhere();
        made++;
      end else if (sel < 68) begin
        push_item(make_item(KIND_PLOT, near_coord(painter.eff_w()), near_coord(painter.eff_h()),
                            any16(), any16(), 16'($urandom)));
        made++;
      end else if (sel < 84) begin
        push_item(make_item(KIND_FILL_RECT, near_coord(painter.eff_w()),
                            near_coord(painter.eff_h()),
                            rect_extent(roomy(), roomy() ? painter.eff_w() + 4 : 24),
                            rect_extent(roomy(), roomy() ? painter.eff_h() + 4 : 24),
                            16'($urandom)));
        made++;
      end else if (sel < 88) begin
        if (roomy())
          push_item(make_item(KIND_FILL_ALL, any16(), any16(), any16(), any16(), 16'($urandom)));
        else
          push_item(make_item(KIND_FILL_RECT, near_coord(painter.eff_w()),
                              near_coord(painter.eff_h()), $urandom_range(1, 20),
                              $urandom_range(1, 20), 16'($urandom)));
        made++;
      end else if (sel < 94) begin
        // Noise: spare kinds, stray pixels and image starts that open nothing.
        case ($urandom_range(0, 2))
          0: push_item(make_item($urandom_range(0, 1) ? KIND_SPARE_LO : KIND_SPARE_HI,
                                 any16(), any16(), any16(), any16(), 16'($urandom)));
          1: push_item(make_item(KIND_IMG_PIXEL, any16(), any16(), any16(), any16(),
                                 16'($urandom)));
          default: push_item(make_item(KIND_IMG_START, any16(), any16(),
                                       -int'($urandom_range(0, 32768)), any16(),
                                       16'($urandom)));
        endcase
      end else begin
        it = in_item_t'({$urandom, $urandom, $urandom});
        if ((it.kind == KIND_FILL_RECT || it.kind == KIND_FILL_ALL) && !roomy())
          it.kind = KIND_READ;
        push_item(it);
        made++;
      end
    end
  endtask

  // Extremes of every field and each special case, under the reset geometry.
  task automatic directed_items();
    // The frame fill comes first so that every store entry is written.
    push_item(make_item(KIND_FILL_ALL, 0, 0, 0, 0, 16'h3c5a));
    push_item(make_item(KIND_READ, 0, 0, 0, 0, 16'h0000));
    push_item(make_item(KIND_READ, 255, 255, 32767, -32768, 16'hffff));
    push_item(make_item(KIND_READ, -1, 0, 0, 0, 16'h0000));
    push_item(make_item(KIND_READ, 0, 256, 0, 0, 16'h0000));
    push_item(make_item(KIND_READ, -32768, 32767, 0, 0, 16'h0000));
    push_item(make_item(KIND_PLOT, 10, 20, 0, 0, 16'hffff));
    push_item(make_item(KIND_PLOT, -5, 3, 0, 0, 16'h0001));
    push_item(make_item(KIND_PLOT, 32767, -32768, 0, 0, 16'h8000));
    push_item(make_item(KIND_READ, 10, 20, 0, 0, 16'h0000));
    // Empty intersections and one fill that runs off the frame corner.
    push_item(make_item(KIND_FILL_RECT, -32768, -32768, 32767, 32767, 16'h1111));
    push_item(make_item(KIND_FILL_RECT, 250, 250, 32767, 32767, 16'ha55a));
    push_item(make_item(KIND_FILL_RECT, 100, 100, 0, 5, 16'h2222));
    push_item(make_item(KIND_FILL_RECT, 100, 100, 5, -32768, 16'h3333));
    push_item(make_item(KIND_READ, 253, 253, 0, 0, 16'h0000));
    // Image hanging over the corner, abandoned by a start that opens nothing.
    push_item(make_item(KIND_IMG_START, 254, 254, 3, 2, 16'h0000));
    push_item(make_item(KIND_IMG_PIXEL, 0, 0, 0, 0, 16'h0001));
    push_item(make_item(KIND_IMG_PIXEL, 0, 0, 0, 0, 16'h8000));
    push_item(make_item(KIND_IMG_PIXEL, 0, 0, 0, 0, 16'h00ff));
    push_item(make_item(KIND_IMG_PIXEL, 0, 0, 0, 0, 16'hff00));
    push_item(make_item(KIND_IMG_START, 5, 5, 0, 4, 16'h0000));
    push_item(make_item(KIND_IMG_PIXEL, 5, 5, 0, 0, 16'h1234));
    push_item(make_item(KIND_SPARE_LO, 1, 1, 1, 1, 16'h5678));
    push_item(make_item(KIND_SPARE_HI, 2, 2, 2, 2, 16'h9abc));
    push_item(make_item(KIND_READ, 254, 254, 0, 0, 16'h0000));
    push_item(make_item(KIND_READ, 255, 255, 0, 0, 16'h0000));
  endtask

  initial begin : stimulus
    int p;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    gap_pct = 15;
    calm_out = 1'b0;
    stall_run = 0;
    settings_used = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed_items();

    // Fixed corner settings first, random ones after; the last phase runs flat out.
    for (p = 0; p < 10; p++) begin
      case (p)
        0: apply_setting(9'd256, 9'd256, 9'd0, 9'd0, 9'd256, 9'd256);
        1: apply_setting(9'd511, 9'd300, 9'd200, 9'd255, 9'd511, 9'd511);
        2: apply_setting(9'd0, 9'd17, 9'd0, 9'd0, 9'd256, 9'd256);
        3: apply_setting(9'd1, 9'd1, 9'd0, 9'd0, 9'd1, 9'd1);
        4: apply_setting(9'd40, 9'd30, 9'd5, 9'd5, 9'd0, 9'd20);
        5: apply_setting(9'd256, 9'd3, 9'd255, 9'd1, 9'd6, 9'd2);
        default: random_setting();
      endcase
      gap_pct = (p == 3 || p == 7 || p == 9) ? 0 : 20;
      calm_out = (p == 5 || p == 9);
      random_items(100, p % 2 == 0);
    end

    drain_results();
    repeat (10) @(posedge clk);
    if (painter.outstanding() != 0) begin
      $display("%0t: %0d readbacks never arrived", $time, painter.outstanding());
      painter.errors += painter.outstanding();
    end
    $display("Sent %0d command beats over %0d register settings; %0d readbacks compared.",
             painter.beats, settings_used, painter.reads_checked);
    $display("Plots, fills and image streams accounted for %0d pixel writes.",
             painter.pixel_writes);
    if (painter.errors == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
